>>> rtl/core/dcf_pkg.sv
// dcf_pkg: types and constants shared by the time code frame decoder
// depends on nothing; imported by every module under rtl/core but dcf_checker
package dcf_pkg;

  localparam int FRAME_LEN = 58;
  localparam int POS_W     = 6;
  localparam int MS_W      = 16;
  localparam int LIMIT_W   = 10;
  localparam int CFG_IDX_W = 3;

  // pulse classes passed from front to back
  localparam int CLS_W = 2;
  localparam logic [CLS_W-1:0] CLS_MARKER = 2'd0;
  localparam logic [CLS_W-1:0] CLS_ONE    = 2'd1;
  localparam logic [CLS_W-1:0] CLS_ZERO   = 2'd2;
  localparam logic [CLS_W-1:0] CLS_BAD    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LIM  = 3'd4;

  // register reset values
  localparam logic [MS_W-1:0]    RST_MARKER_MIN = 16'd1500;
  localparam logic [MS_W-1:0]    RST_ONE_MIN    = 16'd750;
  localparam logic [MS_W-1:0]    RST_ZERO_MIN   = 16'd850;
  localparam logic [MS_W-1:0]    RST_ZERO_MAX   = 16'd950;
  localparam logic [LIMIT_W-1:0] RST_PULSE_LIM  = 10'd300;

  // interval thresholds seen by the classifier
  typedef struct packed {
    logic [MS_W-1:0] marker_min;
    logic [MS_W-1:0] one_min;
    logic [MS_W-1:0] zero_min;
    logic [MS_W-1:0] zero_max;
  } thresh_t;

endpackage

>>> rtl/core/dcf77_frame_decoder.sv
// dcf77_frame_decoder: top level, register file and the front/queue/back chain
// depends on dcf_pkg, dcf_front, dcf_queue, dcf_back
//
// Decodes a DCF77 minute frame from measured low-pulse intervals (ms, saturated).
// One interval is accepted per clock cycle while the queue is not full; the
// classifier writes a class code into a QUEUE_DEPTH-entry queue and the frame
// engine drains one entry per cycle while the output register is free. A result is
// either a watchdog timeout (kind 1, all time fields 0) when more than pulse_limit
// pulses arrive in one session, or a decoded frame (kind 0) after 58 bits following
// a start marker, with time_valid set when minute, hour, day, month and year are
// in range. Timeout wins when both fall on one pulse, and either result restarts
// the session. Registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while no request is in flight (not enforced).
module dcf77_frame_decoder
  import dcf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MS_W-1:0]      cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MS_W-1:0]      pulse_low_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 kind,
  output logic                 time_valid,
  output logic [6:0]           minute_value,
  output logic [5:0]           hour_value,
  output logic [5:0]           day_value,
  output logic [2:0]           weekday_value,
  output logic [4:0]           month_value,
  output logic [7:0]           year_value
);

  thresh_t            thresh;
  logic [LIMIT_W-1:0] pulse_limit;
  logic               push;
  logic [CLS_W-1:0]   push_cls;
  logic               queue_full;
  logic               pop;
  logic               head_valid;
  logic [CLS_W-1:0]   head_cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh.marker_min <= RST_MARKER_MIN;
      thresh.one_min    <= RST_ONE_MIN;
      thresh.zero_min   <= RST_ZERO_MIN;
      thresh.zero_max   <= RST_ZERO_MAX;
      pulse_limit       <= RST_PULSE_LIM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MARKER_MIN: thresh.marker_min <= cfg_data;
        REG_ONE_MIN:    thresh.one_min    <= cfg_data;
        REG_ZERO_MIN:   thresh.zero_min   <= cfg_data;
        REG_ZERO_MAX:   thresh.zero_max   <= cfg_data;
        REG_PULSE_LIM:  pulse_limit       <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  dcf_front u_front (
    .thresh       (thresh),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pulse_low_ms (pulse_low_ms),
    .push         (push),
    .push_cls     (push_cls),
    .queue_full   (queue_full)
  );

  dcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cls   (push_cls),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cls   (head_cls)
  );

  dcf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pulse_limit   (pulse_limit),
    .head_valid    (head_valid),
    .head_cls      (head_cls),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .time_valid    (time_valid),
    .minute_value  (minute_value),
    .hour_value    (hour_value),
    .day_value     (day_value),
    .weekday_value (weekday_value),
    .month_value   (month_value),
    .year_value    (year_value)
  );

endmodule

>>> rtl/core/dcf_front.sv
// dcf_front: sorts each interval into marker, one, zero or bad
// depends on dcf_pkg; feeds dcf_queue
module dcf_front
  import dcf_pkg::*;
(
  input  thresh_t          thresh,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [MS_W-1:0]  pulse_low_ms,
  output logic             push,
  output logic [CLS_W-1:0] push_cls,
  input  logic             queue_full
);

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    priority if (pulse_low_ms > thresh.marker_min) begin
      push_cls = CLS_MARKER;
    end else if (pulse_low_ms >= thresh.one_min && pulse_low_ms < thresh.zero_min) begin
      push_cls = CLS_ONE;
    end else if (pulse_low_ms >= thresh.zero_min && pulse_low_ms < thresh.zero_max) begin
      push_cls = CLS_ZERO;
    end else begin
      push_cls = CLS_BAD;
    end
  end

endmodule

>>> rtl/core/dcf_queue.sv
// dcf_queue: small fifo of pulse classes between front and back
// depends on dcf_pkg
module dcf_queue
  import dcf_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [CLS_W-1:0] push_cls,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [CLS_W-1:0] head_cls
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CLS_W-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cls   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/dcf_back.sv
// dcf_back: frame state, watchdog, bcd decode and output register
// depends on dcf_pkg; consumes classes from dcf_queue
module dcf_back
  import dcf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [LIMIT_W-1:0] pulse_limit,
  input  logic               head_valid,
  input  logic [CLS_W-1:0]   head_cls,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic               time_valid,
  output logic [6:0]         minute_value,
  output logic [5:0]         hour_value,
  output logic [5:0]         day_value,
  output logic [2:0]         weekday_value,
  output logic [4:0]         month_value,
  output logic [7:0]         year_value
);

  logic [FRAME_LEN-1:0] frame_bits;
  logic [FRAME_LEN-1:0] frame_bits_next;
  logic [POS_W-1:0]     bit_position;
  logic [POS_W-1:0]     bit_position_next;
  logic                 in_frame;
  logic                 in_frame_next;
  logic [LIMIT_W-1:0]   pulse_count;
  logic [LIMIT_W:0]     count_inc;
  logic                 timeout;
  logic                 frame_done;
  logic                 result;
  logic [6:0]           mi;
  logic [5:0]           hr;
  logic [5:0]           dy;
  logic [2:0]           wd;
  logic [4:0]           mo;
  logic [7:0]           yr;
  logic                 ok;

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    frame_bits_next   = frame_bits;
    bit_position_next = bit_position;
    in_frame_next     = in_frame;
    if (head_cls == CLS_MARKER) begin
      in_frame_next     = 1'b1;
      bit_position_next = '0;
    end else if (in_frame) begin
      if (head_cls == CLS_ONE || head_cls == CLS_ZERO) begin
        if (bit_position < POS_W'(FRAME_LEN)) begin
          frame_bits_next[bit_position] = (head_cls == CLS_ONE);
        end
        bit_position_next = bit_position + 1'b1;
      end else begin
        in_frame_next = 1'b0;
      end
    end
  end

  assign count_inc  = {1'b0, pulse_count} + 1'b1;
  assign timeout    = count_inc > {1'b0, pulse_limit};
  assign frame_done = in_frame_next && (bit_position_next == POS_W'(FRAME_LEN));
  assign result     = timeout || frame_done;

  // bcd weights 1 2 4 8 10 20 40 80
  assign mi = 7'(frame_bits_next[24:21])
            + (frame_bits_next[25] ? 7'd10 : 7'd0)
            + (frame_bits_next[26] ? 7'd20 : 7'd0)
            + (frame_bits_next[27] ? 7'd40 : 7'd0);
  assign hr = 6'(frame_bits_next[32:29])
            + (frame_bits_next[33] ? 6'd10 : 6'd0)
            + (frame_bits_next[34] ? 6'd20 : 6'd0);
  assign dy = 6'(frame_bits_next[39:36])
            + (frame_bits_next[40] ? 6'd10 : 6'd0)
            + (frame_bits_next[41] ? 6'd20 : 6'd0);
  assign wd = frame_bits_next[44:42];
  assign mo = 5'(frame_bits_next[48:45])
            + (frame_bits_next[49] ? 5'd10 : 5'd0);
  assign yr = 8'(frame_bits_next[53:50])
            + (frame_bits_next[54] ? 8'd10 : 8'd0)
            + (frame_bits_next[55] ? 8'd20 : 8'd0)
            + (frame_bits_next[56] ? 8'd40 : 8'd0)
            + (frame_bits_next[57] ? 8'd80 : 8'd0);
  assign ok = (mi < 7'd60) && (hr < 6'd24) && (dy <= 6'd31)
           && (mo <= 5'd12) && (yr < 8'd100);

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position <= '0;
      in_frame     <= 1'b0;
      pulse_count  <= '0;
    end else if (pop) begin
      if (result) begin
        bit_position <= '0;
        in_frame     <= 1'b0;
        pulse_count  <= '0;
      end else begin
        bit_position <= bit_position_next;
        in_frame     <= in_frame_next;
        pulse_count  <= count_inc[LIMIT_W-1:0];
      end
    end
  end

  // stored bits are always rewritten from bit 0 after a marker
  always_ff @(posedge clk) begin
    if (pop) begin
      frame_bits <= frame_bits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && result) begin
      kind <= timeout;
      if (timeout) begin
        time_valid    <= 1'b0;
        minute_value  <= '0;
        hour_value    <= '0;
        day_value     <= '0;
        weekday_value <= '0;
        month_value   <= '0;
        year_value    <= '0;
      end else begin
        time_valid    <= ok;
        minute_value  <= mi;
        hour_value    <= hr;
        day_value     <= dy;
        weekday_value <= wd;
        month_value   <= mo;
        year_value    <= yr;
      end
    end
  end

endmodule

>>> rtl/core/dcf_checker.sv
// dcf_checker: port-level checks on the frame decoder, bound to the top level
// depends on the result ports of dcf77_frame_decoder
module dcf_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       kind,
  input logic       time_valid,
  input logic [6:0] minute_value,
  input logic [5:0] hour_value,
  input logic [5:0] day_value,
  input logic [2:0] weekday_value,
  input logic [4:0] month_value,
  input logic [7:0] year_value
);

  // no result can be pending right after reset
  a_rst_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result keeps its kind, time_valid, minute and year
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(time_valid)
      && $stable(minute_value) && $stable(year_value))
    else $error("stalled result changed");

  // timeout results carry no time
  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> !time_valid && minute_value == '0 && hour_value == '0
      && day_value == '0 && weekday_value == '0 && month_value == '0
      && year_value == '0)
    else $error("timeout result with time fields set");

  // valid flag agrees with the field ranges
  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind && time_valid |-> minute_value < 7'd60 && hour_value < 6'd24
      && day_value <= 6'd31 && month_value <= 5'd12 && year_value < 8'd100)
    else $error("time_valid set on out-of-range field");

endmodule

bind dcf77_frame_decoder dcf_checker u_dcf_checker (.*);
